[sv/id3p_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3p_pkg
// Shared types, codes and tag table for the ID3v2 text frame parser.
// ----------------------------------------------------------------------------
package id3p_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  localparam logic [2:0] NO_MATCH = 3'd7;
  localparam int         NUM_TAGS = 6;

  // Header byte counter limits (file header and frame header are both 10 bytes).
  localparam logic [3:0] HDR_LAST = 4'd9;
  localparam logic [3:0] ID_END   = 4'd4;
  localparam logic [3:0] SIZE_END = 4'd8;

  localparam logic [31:0] TAG_CODES [NUM_TAGS] = '{
    32'h54495432, // TIT2 title
    32'h54504531, // TPE1 artist
    32'h54414C42, // TALB album
    32'h54594552, // TYER year
    32'h54434F4E, // TCON genre
    32'h434F4D4D  // COMM comment
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] tag;
    logic [7:0] ch;
  } res_t;

  // Up to two results caused by one input byte.
  typedef struct packed {
    logic two;
    res_t r1;
    res_t r0;
  } rec_t;

  function automatic logic [2:0] lookup_tag(input logic [31:0] id);
    logic [2:0] idx;
    idx = NO_MATCH;
    for (int i = NUM_TAGS - 1; i >= 0; i--) begin
      if (TAG_CODES[i] == id) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage

[sv/id3p_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3p_front
// Byte parser: walks file header, frame headers and frame data, and turns
// each accepted byte into no record or one record of one or two results.
// ----------------------------------------------------------------------------
module id3p_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        data_byte,
  input  logic              start_of_file,
  output logic              push,
  output id3p_pkg::rec_t    rec
);

  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_FHDR = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        first_r, first_nxt;
  logic [2:0]  match_r, match_nxt;
  logic        fin_r, fin_nxt;

  logic [1:0]  ph_cur;
  logic [3:0]  pos_cur;
  logic        emit_a, emit_b;
  id3p_pkg::res_t res_a, res_b;

  // A start-of-file byte restarts the parse; only phase and position matter,
  // the rest is rewritten before it is used again.
  assign ph_cur  = start_of_file ? PH_SKIP : phase_r;
  assign pos_cur = start_of_file ? 4'd0 : pos_r;

  always_comb begin
    phase_nxt = ph_cur;
    pos_nxt   = pos_cur;
    id_nxt    = id_r;
    size_nxt  = size_r;
    rem_nxt   = rem_r;
    first_nxt = first_r;
    match_nxt = match_r;
    fin_nxt   = fin_r;
    emit_a    = 1'b0;
    emit_b    = 1'b0;
    res_a     = '0;
    res_b     = '{kind: id3p_pkg::KIND_END, tag: match_r, ch: 8'd0};
    unique case (ph_cur)
      PH_SKIP: begin
        if (pos_cur >= id3p_pkg::HDR_LAST) begin
          phase_nxt = PH_FHDR;
          pos_nxt   = 4'd0;
        end else begin
          pos_nxt = pos_cur + 4'd1;
        end
      end
      PH_FHDR: begin
        if (pos_cur == 4'd0 && data_byte == 8'd0) begin
          emit_a    = 1'b1;
          res_a     = '{kind: id3p_pkg::KIND_STOP, tag: 3'd0, ch: 8'd0};
          phase_nxt = PH_STOP;
        end else begin
          if (pos_cur < id3p_pkg::ID_END) begin
            id_nxt = {id_r[23:0], data_byte};
          end else if (pos_cur < id3p_pkg::SIZE_END) begin
            size_nxt = {size_r[23:0], data_byte};
          end
          if (pos_cur >= id3p_pkg::HDR_LAST) begin
            pos_nxt   = 4'd0;
            match_nxt = id3p_pkg::lookup_tag(id_r);
            rem_nxt   = size_r;
            first_nxt = 1'b1;
            fin_nxt   = 1'b0;
            if (size_r == 32'd0) begin
              if (match_nxt != id3p_pkg::NO_MATCH) begin
                emit_a = 1'b1;
                res_a  = '{kind: id3p_pkg::KIND_END, tag: match_nxt, ch: 8'd0};
              end
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            pos_nxt = pos_cur + 4'd1;
          end
        end
      end
      PH_DATA: begin
        if (match_r != id3p_pkg::NO_MATCH && !fin_r && !first_r) begin
          emit_a = 1'b1;
          if (data_byte == 8'd0) begin
            res_a   = '{kind: id3p_pkg::KIND_END, tag: match_r, ch: 8'd0};
            fin_nxt = 1'b1;
          end else begin
            res_a = '{kind: id3p_pkg::KIND_CHAR, tag: match_r, ch: data_byte};
          end
        end
        first_nxt = 1'b0;
        rem_nxt   = rem_r - 32'd1;
        if (rem_r == 32'd1) begin
          // Text that runs to the end of the frame still gets its end mark.
          if (match_r != id3p_pkg::NO_MATCH && !fin_nxt) begin
            emit_b  = 1'b1;
            fin_nxt = 1'b1;
          end
          phase_nxt = PH_FHDR;
          pos_nxt   = 4'd0;
        end
      end
      PH_STOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rec = '0;
    if (emit_a) begin
      rec.r0  = res_a;
      rec.r1  = res_b;
      rec.two = emit_b;
    end else begin
      rec.r0 = res_b;
    end
  end

  assign push = in_fire && (emit_a || emit_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      pos_r   <= 4'd0;
      id_r    <= 32'd0;
      size_r  <= 32'd0;
      rem_r   <= 32'd0;
      first_r <= 1'b1;
      match_r <= id3p_pkg::NO_MATCH;
      fin_r   <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      id_r    <= id_nxt;
      size_r  <= size_nxt;
      rem_r   <= rem_nxt;
      first_r <= first_nxt;
      match_r <= match_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

[sv/id3p_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3p_queue
// Short FIFO of result records between the parser and the output stage.
// ----------------------------------------------------------------------------
module id3p_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  id3p_pkg::rec_t push_rec,
  input  logic           pop,
  output id3p_pkg::rec_t head_rec,
  output logic           empty,
  output logic           full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  id3p_pkg::rec_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign empty    = (cnt_r == CW'(0));
  assign full     = (cnt_r == CW'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

[sv/id3p_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3p_back
// Output stage: takes records from the queue and hands out one result per
// request on the output stream, holding a second result until its turn.
// ----------------------------------------------------------------------------
module id3p_back (
  input  logic           clk,
  input  logic           rst_n,
  input  id3p_pkg::rec_t head_rec,
  input  logic           empty,
  output logic           pop,
  input  logic           out_tready,
  output logic           out_tvalid,
  output id3p_pkg::res_t out_res
);

  logic           valid_r;
  logic           pend_valid_r;
  id3p_pkg::res_t res_r, pend_r;
  logic           out_fire;
  logic           free;

  assign out_fire   = valid_r && out_tready;
  // The output register frees up when it is empty or its last result leaves.
  assign free       = !valid_r || (out_fire && !pend_valid_r);
  assign pop        = free && !empty;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (out_fire && pend_valid_r) begin
      pend_valid_r <= 1'b0;
    end else if (pop) begin
      valid_r      <= 1'b1;
      pend_valid_r <= head_rec.two;
    end else if (out_fire) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire && pend_valid_r) begin
      res_r <= pend_r;
    end else if (pop) begin
      res_r  <= head_rec.r0;
      pend_r <= head_rec.r1;
    end
  end

endmodule

[sv/id3v2_text_frame_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3v2_text_frame_parser_core
// Extracts the text of title, artist, album, year, genre and comment frames
// from an ID3v2 tagged file streamed in one byte per request.
// ----------------------------------------------------------------------------
// Input stream: one file byte per request, in_tuser marks the first byte of a
// file and restarts the parse. Output stream: one result per request, a text
// character, an end-of-field mark or a single parsing-stopped report.
// The parser takes one byte per cycle while in_tready is high and updates
// only counters and compares; results pass the queue and output register.
// The last data byte of a text frame with no null causes two results, which
// leave one after the other; the record queue between parser and output
// register (QUEUE_DEPTH records, at least 2) absorbs this, and input stalls
// only when that queue is full. When the receiver holds out_tready low the
// current result stays on the port and the queue fills, then in_tready falls.
// Reset (rst_n low, synchronous) empties the queue and the output register
// and puts the parser back to skipping the file header.
// ----------------------------------------------------------------------------
module id3v2_text_frame_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] start_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] tag_index, [10:3] text_byte, rest zero
  output logic [1:0]  out_tuser   // [1:0] kind
);

  logic           in_fire;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;
  id3p_pkg::rec_t push_rec;
  id3p_pkg::rec_t head_rec;
  id3p_pkg::res_t out_res;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  id3p_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .data_byte     (in_tdata),
    .start_of_file (in_tuser[0]),
    .push          (push),
    .rec           (push_rec)
  );

  id3p_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (q_empty),
    .full     (q_full)
  );

  id3p_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_rec   (head_rec),
    .empty      (q_empty),
    .pop        (pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tdata = {5'd0, out_res.ch, out_res.tag};
  assign out_tuser = out_res.kind;

endmodule

[sv/id3p_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3p_checker
// Port-level checks on the parser's output stream.
// ----------------------------------------------------------------------------
module id3p_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output result changed while stalled");

  // Stop reports carry no tag and no character.
  a_stop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == id3p_pkg::KIND_STOP |-> out_tdata == 16'd0)
    else $error("stop report with nonzero payload");

  // End marks carry no character.
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == id3p_pkg::KIND_END |-> out_tdata[15:3] == 13'd0)
    else $error("end mark with nonzero character");

  // Only the six known tags and the three kinds ever appear.
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == id3p_pkg::KIND_CHAR || out_tuser == id3p_pkg::KIND_END ||
                    out_tuser == id3p_pkg::KIND_STOP) &&
                   out_tdata[2:0] < 3'(id3p_pkg::NUM_TAGS))
    else $error("invalid kind or tag index");

endmodule

bind id3v2_text_frame_parser_core id3p_checker u_id3p_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[dv/id3p_text_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3p_text_checker
// Watches both streams of the ID3v2 text frame parser, works out the text
// results that each accepted file byte should cause, and compares them in
// order with the results the parser delivers.
// ----------------------------------------------------------------------------
module id3p_text_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] start_of_file
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [2:0] tag_index, [10:3] text_byte, rest zero
  input  logic [1:0]  out_tuser,  // [1:0] kind
  output int          fail_count,
  output int          results_due
);

  typedef enum logic [1:0] {SKIP_HDR, FRAME_HDR, FRAME_BODY, HALTED} parse_phase_t;

  parse_phase_t phase;
  logic [3:0]   hdr_pos;
  logic [31:0]  frame_id;
  logic [31:0]  frame_size;
  logic [31:0]  body_left;
  logic         body_first;
  logic [2:0]   field_tag;
  logic         field_done;

  id3p_pkg::res_t tag_text_due[$];
  int             errs = 0;
  id3p_pkg::res_t seen;
  id3p_pkg::res_t want;

  assign fail_count = errs;

  task automatic reset_parser();
    phase      = SKIP_HDR;
    hdr_pos    = '0;
    frame_id   = '0;
    frame_size = '0;
    body_left  = '0;
    body_first = 1'b1;
    field_tag  = id3p_pkg::NO_MATCH;
    field_done = 1'b0;
  endtask

  function automatic logic [2:0] tag_of(input logic [31:0] id);
    logic [2:0] hit;
    hit = id3p_pkg::NO_MATCH;
    for (int i = 0; i < id3p_pkg::NUM_TAGS; i++) begin
      if (hit == id3p_pkg::NO_MATCH && id3p_pkg::TAG_CODES[i] == id) hit = 3'(i);
    end
    return hit;
  endfunction

  task automatic queue_result(input logic [1:0] kind, input logic [2:0] tag,
                              input logic [7:0] ch);
    id3p_pkg::res_t r;
    r.kind = kind;
    r.tag  = tag;
    r.ch   = ch;
    tag_text_due.push_back(r);
  endtask

  task automatic parse_file_byte(input logic [7:0] b, input logic sof);
    if (sof) reset_parser();
    case (phase)
      SKIP_HDR: begin
        if (hdr_pos >= id3p_pkg::HDR_LAST) begin
          phase   = FRAME_HDR;
          hdr_pos = '0;
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end
      FRAME_HDR: begin
        if (hdr_pos == 4'd0 && b == 8'h00) begin
          // A zero where an id should start ends the tag area until a new file starts.
          queue_result(id3p_pkg::KIND_STOP, 3'd0, 8'h00);
          phase = HALTED;
        end else begin
          if (hdr_pos < id3p_pkg::ID_END) frame_id = {frame_id[23:0], b};
          else if (hdr_pos < id3p_pkg::SIZE_END) frame_size = {frame_size[23:0], b};
          if (hdr_pos >= id3p_pkg::HDR_LAST) begin
            hdr_pos    = '0;
            field_tag  = tag_of(frame_id);
            body_left  = frame_size;
            body_first = 1'b1;
            field_done = 1'b0;
            if (frame_size == 32'd0) begin
              if (field_tag != id3p_pkg::NO_MATCH) begin
                queue_result(id3p_pkg::KIND_END, field_tag, 8'h00);
              end
            end else begin
              phase = FRAME_BODY;
            end
          end else begin
            hdr_pos = hdr_pos + 4'd1;
          end
        end
      end
      FRAME_BODY: begin
        // The first body byte is the text encoding and is never shown.
        if (field_tag != id3p_pkg::NO_MATCH && !field_done && !body_first) begin
          if (b == 8'h00) begin
            queue_result(id3p_pkg::KIND_END, field_tag, 8'h00);
            field_done = 1'b1;
          end else begin
            queue_result(id3p_pkg::KIND_CHAR, field_tag, b);
          end
        end
        body_first = 1'b0;
        body_left  = body_left - 32'd1;
        if (body_left == 32'd0) begin
          if (field_tag != id3p_pkg::NO_MATCH && !field_done) begin
            queue_result(id3p_pkg::KIND_END, field_tag, 8'h00);
            field_done = 1'b1;
          end
          phase   = FRAME_HDR;
          hdr_pos = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_parser();
      tag_text_due.delete();
    end else begin
      if (in_tvalid && in_tready) parse_file_byte(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready) begin
        seen.kind = out_tuser;
        seen.tag  = out_tdata[2:0];
        seen.ch   = out_tdata[10:3];
        if (tag_text_due.size() == 0) begin
          $error("unexpected result: kind %0d tag_index %0d text_byte %02h",
                 seen.kind, seen.tag, seen.ch);
          errs++;
        end else begin
          want = tag_text_due.pop_front();
          if (seen.kind != want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, seen.kind);
            errs++;
          end
          if (seen.tag != want.tag) begin
            $error("tag_index: expected %0d, actual %0d", want.tag, seen.tag);
            errs++;
          end
          if (seen.ch != want.ch) begin
            $error("text_byte: expected %02h, actual %02h", want.ch, seen.ch);
            errs++;
          end
          if (out_tdata[15:11] != 5'd0) begin
            $error("tdata padding: expected 0, actual %0h", out_tdata[15:11]);
            errs++;
          end
        end
      end
    end
    results_due <= tag_text_due.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams tagged files into the ID3v2 text frame parser: a directed set of
// frames covering each text field and the corner cases of frame sizes, nulls
// and the stop byte, then random files with random idling on both streams.
// The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_BYTES = 50;
  localparam logic [31:0] ID_TXXX = 32'h54585858;
  localparam logic [31:0] ID_TIT3 = 32'h54495433;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [0:0]  in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fail_count;
  int          results_due;

  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          live_bytes = 0;
  int          quiet_cycles = 0;
  logic [7:0]  body[$];

  always #5 clk = ~clk;

  id3v2_text_frame_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  id3p_text_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Bytes that the parser ignores after a stop are sent with live low so that
  // they do not count toward the stimulus length.
  task automatic send_byte(input logic [7:0] b, input logic sof, input bit live);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= sof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (live) live_bytes++;
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_file_header(input bit with_sof);
    for (int i = 0; i < 10; i++) begin
      send_byte(8'($urandom), with_sof && (i == 0), 1'b1);
    end
  endtask

  // Sends the frame header and then whatever is in body, which may be
  // shorter than the size when the frame is meant to be cut off.
  task automatic send_frame(input logic [31:0] id, input logic [31:0] size);
    for (int i = 3; i >= 0; i--) send_byte(id[8*i +: 8], 1'b0, 1'b1);
    for (int i = 3; i >= 0; i--) send_byte(size[8*i +: 8], 1'b0, 1'b1);
    send_byte(8'($urandom), 1'b0, 1'b1);
    send_byte(8'($urandom), 1'b0, 1'b1);
    foreach (body[i]) send_byte(body[i], 1'b0, 1'b1);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // First file arrives with no start flag at all.
    send_file_header(1'b0);
    body = {};
    send_frame(id3p_pkg::TAG_CODES[0], 32'd0);
    body = '{8'h03};
    send_frame(id3p_pkg::TAG_CODES[1], 32'd1);
    body = '{8'h00, 8'h41, 8'h00, 8'h42, 8'h43};
    send_frame(id3p_pkg::TAG_CODES[2], 32'd5);
    body = '{8'h03, 8'hFF, 8'h01, 8'h39};
    send_frame(id3p_pkg::TAG_CODES[3], 32'd4);
    body = '{8'h00, 8'h00};
    send_frame(id3p_pkg::TAG_CODES[4], 32'd2);
    body = '{8'h00, 8'h80, 8'h7F};
    send_frame(id3p_pkg::TAG_CODES[5], 32'd3);
    body = '{8'h01, 8'h02, 8'h03};
    send_frame(ID_TXXX, 32'd3);
    body = {};
    send_frame(ID_TIT3, 32'd0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h54, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    // Largest sizes: the frames are abandoned by a new file.
    send_file_header(1'b1);
    body = '{8'h11, 8'h22, 8'h33};
    send_frame(ID_TXXX, 32'hFFFF_FFFF);
    send_file_header(1'b1);
    body = '{8'h00, 8'h61, 8'h62, 8'hFE};
    send_frame(id3p_pkg::TAG_CODES[0], 32'h8000_0000);
    send_file_header(1'b1);
    body = '{8'h00, 8'h78};
    send_frame(id3p_pkg::TAG_CODES[0], 32'd2);
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  task automatic send_random_file();
    int          frames;
    int          pick;
    int          len;
    logic [31:0] id;
    logic [31:0] size;
    bit          cut;
    send_file_header(1'b1);
    frames = $urandom_range(1, 4);
    for (int f = 0; f < frames; f++) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        id = id3p_pkg::TAG_CODES[$urandom_range(id3p_pkg::NUM_TAGS - 1)];
      end else if (pick < 80) begin
        id = id3p_pkg::TAG_CODES[$urandom_range(id3p_pkg::NUM_TAGS - 1)] ^
             (32'd1 << $urandom_range(31));
      end else begin
        id = $urandom;
      end
      if (id[31:24] == 8'h00) id[31:24] = 8'h41;
      pick = $urandom_range(99);
      if (pick < 90) size = $urandom_range(0, 8);
      else if (pick < 96) size = $urandom_range(9, 24);
      else size = {8'($urandom_range(1, 255)), 24'($urandom)};
      // Occasionally a frame is cut short and the next file restarts the parse.
      cut = (size > 24) || ($urandom_range(99) < 5);
      len = (size > 24) ? $urandom_range(0, 6) : (cut ? $urandom_range(0, size) : size);
      body = {};
      for (int i = 0; i < len; i++) begin
        body.push_back(($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(1, 255)));
      end
      send_frame(id, size);
      if (cut) return;
    end
    pick = $urandom_range(99);
    if (pick < 50) begin
      send_byte(8'h00, 1'b0, 1'b1);
      len = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) send_byte(8'($urandom), 1'b0, 1'b0);
    end else if (pick < 60) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_byte(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  initial begin
    int gap_by_phase[4];
    int stall_by_phase[4];
    int target;
    gap_by_phase   = '{0, 70, 0, 10};
    stall_by_phase = '{0, 0, 70, 10};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 4; p++) begin
      send_gap_pct   = gap_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      if (p == 0) run_directed();
      target = live_bytes + PHASE_BYTES;
      while (live_bytes < target) send_random_file();
      // The sender holds off until every pending result has been delivered.
      wait_results_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
